>>> sv/icfr_pkg.sv
// Shared constants, types and helpers for the implicit curve fit residual block.
`default_nettype none
package icfr_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int COEF_W     = 32;
	localparam int ACC_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int PROD_W     = ACC_W + COEF_W;
	localparam int MAGN_W     = COEF_W + 1 + FRAC_BITS;
	localparam int DEN_W      = COEF_W + 1;
	localparam int NUM_REGS   = 6;
	localparam int ADDR_W     = 5;
	localparam int IDX_W      = ADDR_W - 2;

	localparam logic signed [ACC_W-1:0] SMAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMIN = {1'b1, {(ACC_W-2){1'b0}}, 1'b1};
	localparam logic signed [ACC_W-1:0] DMAX = SMAX >>> FRAC_BITS;
	localparam logic signed [COEF_W-1:0] QUAD_RESET = COEF_W'(64'd1 << FRAC_BITS);

	localparam logic [IDX_W-1:0] REG_QUAD   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_LIN    = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_CUBE   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_SQUARE = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_SLOPE  = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_OFFSET = IDX_W'(5);

	typedef struct packed {
		logic [11:0] x_coord;
		logic [11:0] y_coord;
		logic        last_point;
	} in_word_t;

	typedef struct packed {
		logic [31:0] error_root;
		logic        invalid;
		logic        saturated;
	} out_word_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] quad;
		logic signed [COEF_W-1:0] lin;
		logic signed [COEF_W-1:0] cube;
		logic signed [COEF_W-1:0] square;
		logic signed [COEF_W-1:0] slope;
		logic signed [COEF_W-1:0] offset;
	} coef_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHK, ST_X2, ST_X3, ST_T1, ST_T2, ST_T3, ST_T4, ST_AR, ST_BB,
		ST_DISC, ST_SQ, ST_DIV1, ST_DIV2, ST_DIST, ST_RES, ST_ACC, ST_FIN, ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_X2, OP_X3, OP_T1, OP_T2, OP_T3, OP_T4, OP_AR, OP_BB,
		OP_DISC, OP_SQ, OP_DIV1, OP_DIV2, OP_DIST, OP_RES, OP_ACC, OP_FIN
	} op_t;

	typedef struct packed {
		op_t  op;
		logic go;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic sqrt_done;
		logic div_done;
		logic a_zero;
		logic d_neg;
		logic last;
	} dp_stat_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] val;
		logic                    ovf;
	} sat_t;

	function automatic sat_t sadd(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		sat_t r;
		s = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
		if (s > $signed({1'b0, SMAX})) begin
			r.val = SMAX;
			r.ovf = 1'b1;
		end else if (s < $signed({SMIN[ACC_W-1], SMIN})) begin
			r.val = SMIN;
			r.ovf = 1'b1;
		end else begin
			r.val = s[ACC_W-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [COEF_W-1:0] cmag(input logic signed [COEF_W-1:0] c);
		logic signed [COEF_W-1:0] n;
		n = -c;
		return c[COEF_W-1] ? $unsigned(n) : $unsigned(c);
	endfunction

	function automatic logic [ACC_W-1:0] amag(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] n;
		n = -v;
		return v[ACC_W-1] ? $unsigned(n) : $unsigned(v);
	endfunction

endpackage
`default_nettype wire

>>> sv/icfr_sqrt.sv
// Bit-pair iterative integer square root, one result bit per cycle.
`default_nettype none
module icfr_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [icfr_pkg::ACC_W-1:0]  v,
	output logic                             done,
	output logic [icfr_pkg::ROOT_W-1:0]      root
);
	import icfr_pkg::*;

	logic             busy_q, done_q;
	logic [ACC_W-1:0] rem_q, res_q, bit_q, trial;

	assign trial = res_q + bit_q;
	assign done  = done_q;
	assign root  = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= v;
			res_q <= '0;
			bit_q <= ACC_W'(1) << (ACC_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule
`default_nettype wire

>>> sv/icfr_div.sv
// Restoring signed divider truncating toward zero, one quotient bit per cycle.
`default_nettype none
module icfr_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [icfr_pkg::MAGN_W-1:0] num_mag,
	input  wire logic [icfr_pkg::DEN_W-1:0]  den_mag,
	input  wire logic                        neg,
	output logic                             done,
	output logic signed [icfr_pkg::ACC_W-1:0] quo
);
	import icfr_pkg::*;

	localparam int CNT_W = $clog2(MAGN_W + 1);

	logic              busy_q, done_q, neg_q, fits;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAGN_W-1:0] nq_q;
	logic [DEN_W:0]    rem_q, rsh, rdif;
	logic [DEN_W-1:0]  den_q;
	logic signed [ACC_W-1:0] qpos;

	assign rsh  = {rem_q[DEN_W-1:0], nq_q[MAGN_W-1]};
	assign fits = rsh >= {1'b0, den_q};
	assign rdif = rsh - {1'b0, den_q};
	assign qpos = $signed(ACC_W'(nq_q));
	assign quo  = neg_q ? -qpos : qpos;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MAGN_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			nq_q  <= num_mag;
			den_q <= den_mag;
			neg_q <= neg;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rdif : rsh;
			nq_q  <= {nq_q[MAGN_W-2:0], fits};
		end
	end

endmodule
`default_nettype wire

>>> sv/icfr_dp.sv
// Datapath: point registers, shared multiplier, root and divider units, accumulator.
`default_nettype none
module icfr_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire icfr_pkg::dp_cmd_t   cmd,
	output icfr_pkg::dp_stat_t       stat,
	input  wire icfr_pkg::coef_t     coef,
	input  wire icfr_pkg::in_word_t  in_word,
	output icfr_pkg::out_word_t      out_word
);
	import icfr_pkg::*;

	logic [COORD_BITS-1:0]   x_q, y_q;
	logic                    last_q, ptsat_q, inv_q, satseen_q, big_q;
	logic [ACC_W-1:0]        x2_q, x3_q, m1_q, m2_q, res_q, sum_q;
	logic signed [ACC_W-1:0] r_q, t_q, bb_q, d_q, r1_q, r2_q;
	logic [ROOT_W-1:0]       s_q;
	out_word_t               out_q;

	logic [2:0]              mph_q;
	logic [COEF_W-1:0]       ma_q, mul_a, msel;
	logic [ACC_W-1:0]        mb_q, mul_b, lo_q, hi_q, pp, mraw_q;
	logic                    mneg_q, mul_n, mul_go, movf_q;
	logic [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0] mres_q, ppos;
	logic                    povf;

	logic                    sq_go, sq_done, dv_go, dv_done, dv_neg;
	logic [ACC_W-1:0]        sq_in;
	logic [ROOT_W-1:0]       sq_root;
	logic signed [COEF_W+2:0] bx, sx, nb, nbn;
	logic [MAGN_W-1:0]       dv_num;
	logic [DEN_W-1:0]        dv_den;
	logic signed [ACC_W-1:0] dv_quo;

	sat_t                    addm, addc;
	logic signed [ACC_W-1:0] pterm, dsum, yq;
	logic [ACC_W-1:0]        dist_min;
	logic                    dist_big, sum_big;
	logic [ACC_W:0]          acc;

	assign msel = (mph_q == 3'd1) ? mb_q[COEF_W-1:0] : mb_q[ACC_W-1:COEF_W];
	assign pp   = ma_q * msel;
	assign povf = |prod_q[PROD_W-1:ACC_W-1];
	assign ppos = $signed({1'b0, prod_q[ACC_W-2:0]});

	always_comb begin
		mul_go = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		mul_n  = 1'b0;
		case (cmd.op)
			OP_X2: begin
				mul_go = cmd.go;
				mul_a  = COEF_W'(x_q);
				mul_b  = ACC_W'(x_q);
			end
			OP_X3: begin
				mul_go = cmd.go;
				mul_a  = COEF_W'(x_q);
				mul_b  = x2_q;
			end
			OP_T1: begin
				mul_go = cmd.go;
				mul_a  = cmag(coef.cube);
				mul_b  = x3_q;
				mul_n  = coef.cube[COEF_W-1];
			end
			OP_T2: begin
				mul_go = cmd.go;
				mul_a  = cmag(coef.square);
				mul_b  = x2_q;
				mul_n  = coef.square[COEF_W-1];
			end
			OP_T3: begin
				mul_go = cmd.go;
				mul_a  = cmag(coef.slope);
				mul_b  = ACC_W'(x_q);
				mul_n  = coef.slope[COEF_W-1];
			end
			OP_AR: begin
				mul_go = cmd.go;
				mul_a  = cmag(coef.quad);
				mul_b  = amag(r_q);
				mul_n  = coef.quad[COEF_W-1] ^ r_q[ACC_W-1];
			end
			OP_BB: begin
				mul_go = cmd.go;
				mul_a  = cmag(coef.lin);
				mul_b  = ACC_W'(cmag(coef.lin));
			end
			OP_RES: begin
				mul_go = cmd.go;
				mul_a  = dist_min[ROOT_W-1:0];
				mul_b  = ACC_W'(dist_min[ROOT_W-1:0]);
			end
			default: ;
		endcase
	end

	assign addm     = sadd(r_q, mres_q);
	assign addc     = sadd(r_q, ACC_W'(coef.offset));
	assign pterm    = (t_q >>> FRAC_BITS) <<< 2;
	assign dsum     = bb_q + pterm;
	assign yq       = $signed(ACC_W'({y_q, {FRAC_BITS{1'b0}}}));
	assign dist_min = (m1_q < m2_q) ? m1_q : m2_q;
	assign dist_big = |dist_min[ACC_W-1:ROOT_W];
	assign acc      = {1'b0, sum_q} + {1'b0, res_q};
	assign sum_big  = |sum_q[ACC_W-1:ACC_W-FRAC_BITS];

	assign sq_go = cmd.go && (cmd.op == OP_SQ || cmd.op == OP_FIN);
	assign sq_in = (cmd.op == OP_FIN) ? (sum_q << FRAC_BITS) : ($unsigned(d_q) << FRAC_BITS);

	assign bx     = (COEF_W+3)'(coef.lin);
	assign sx     = $signed({3'b000, s_q});
	assign nb     = (cmd.op == OP_DIV2) ? (-bx - sx) : (-bx + sx);
	assign nbn    = -nb;
	assign dv_num = {(nb[COEF_W+2] ? nbn[COEF_W:0] : nb[COEF_W:0]), {FRAC_BITS{1'b0}}};
	assign dv_den = {cmag(coef.quad), 1'b0};
	assign dv_neg = nb[COEF_W+2] ^ coef.quad[COEF_W-1];
	assign dv_go  = cmd.go && (cmd.op == OP_DIV1 || cmd.op == OP_DIV2);

	icfr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sq_go),
		.v      (sq_in),
		.done   (sq_done),
		.root   (sq_root)
	);

	icfr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (dv_go),
		.num_mag (dv_num),
		.den_mag (dv_den),
		.neg     (dv_neg),
		.done    (dv_done),
		.quo     (dv_quo)
	);

	always_comb begin
		stat.mul_done  = (mph_q == 3'd5);
		stat.sqrt_done = sq_done;
		stat.div_done  = dv_done;
		stat.a_zero    = (coef.quad == '0);
		stat.d_neg     = dsum[ACC_W-1];
		stat.last      = last_q;
	end

	assign out_word = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mph_q     <= '0;
			sum_q     <= '0;
			inv_q     <= 1'b0;
			satseen_q <= 1'b0;
		end else begin
			if (mul_go) begin
				mph_q <= 3'd1;
			end else if (mph_q == 3'd5) begin
				mph_q <= '0;
			end else if (mph_q != '0) begin
				mph_q <= mph_q + 3'd1;
			end
			case (cmd.op)
				OP_LOAD: begin
					if (cmd.go && coef.quad == '0) begin
						inv_q <= 1'b1;
					end
				end
				OP_DISC: begin
					if (cmd.go && dsum[ACC_W-1]) begin
						inv_q     <= 1'b1;
						satseen_q <= satseen_q | ptsat_q;
					end
				end
				OP_ACC: begin
					if (cmd.go) begin
						sum_q     <= acc[ACC_W] ? '1 : acc[ACC_W-1:0];
						satseen_q <= satseen_q | ptsat_q | acc[ACC_W];
					end
				end
				OP_FIN: begin
					if (sq_done) begin
						sum_q     <= '0;
						inv_q     <= 1'b0;
						satseen_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			ma_q   <= mul_a;
			mb_q   <= mul_b;
			mneg_q <= mul_n;
		end
		if (mph_q == 3'd1) begin
			lo_q <= pp;
		end
		if (mph_q == 3'd2) begin
			hi_q <= pp;
		end
		if (mph_q == 3'd3) begin
			prod_q <= {hi_q, {COEF_W{1'b0}}} + PROD_W'(lo_q);
		end
		if (mph_q == 3'd4) begin
			movf_q <= povf;
			mraw_q <= prod_q[ACC_W-1:0];
			if (povf) begin
				mres_q <= mneg_q ? SMIN : SMAX;
			end else begin
				mres_q <= mneg_q ? -ppos : ppos;
			end
		end
		case (cmd.op)
			OP_LOAD: begin
				if (cmd.go) begin
					x_q     <= in_word.x_coord[COORD_BITS-1:0];
					y_q     <= in_word.y_coord[COORD_BITS-1:0];
					last_q  <= in_word.last_point;
					ptsat_q <= 1'b0;
				end
			end
			OP_X2: begin
				if (mph_q == 3'd5) begin
					x2_q <= mraw_q;
				end
			end
			OP_X3: begin
				if (mph_q == 3'd5) begin
					x3_q <= mraw_q;
				end
			end
			OP_T1: begin
				if (mph_q == 3'd5) begin
					r_q     <= mres_q;
					ptsat_q <= ptsat_q | movf_q;
				end
			end
			OP_T2, OP_T3: begin
				if (mph_q == 3'd5) begin
					r_q     <= addm.val;
					ptsat_q <= ptsat_q | movf_q | addm.ovf;
				end
			end
			OP_T4: begin
				if (cmd.go) begin
					r_q     <= addc.val;
					ptsat_q <= ptsat_q | addc.ovf;
				end
			end
			OP_AR: begin
				if (mph_q == 3'd5) begin
					t_q     <= mres_q;
					ptsat_q <= ptsat_q | movf_q;
				end
			end
			OP_BB: begin
				if (mph_q == 3'd5) begin
					bb_q <= $signed(mraw_q >> FRAC_BITS);
				end
			end
			OP_DISC: begin
				if (cmd.go && !dsum[ACC_W-1]) begin
					d_q     <= (dsum > DMAX) ? DMAX : dsum;
					ptsat_q <= ptsat_q | (dsum > DMAX);
				end
			end
			OP_SQ: begin
				if (sq_done) begin
					s_q <= sq_root;
				end
			end
			OP_DIV1: begin
				if (dv_done) begin
					r1_q <= dv_quo;
				end
			end
			OP_DIV2: begin
				if (dv_done) begin
					r2_q <= dv_quo;
				end
			end
			OP_DIST: begin
				if (cmd.go) begin
					m1_q <= amag(yq - r1_q);
					m2_q <= amag(yq - r2_q);
				end
			end
			OP_RES: begin
				if (cmd.go) begin
					big_q <= dist_big;
				end
				if (mph_q == 3'd5) begin
					res_q   <= big_q ? '1 : (mraw_q >> FRAC_BITS);
					ptsat_q <= ptsat_q | big_q;
				end
			end
			OP_FIN: begin
				if (sq_done) begin
					out_q.error_root <= sum_big ? '1 : sq_root;
					out_q.invalid    <= inv_q;
					out_q.saturated  <= satseen_q | sum_big;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> sv/icfr_ctrl.sv
// Controller: sequences the datapath steps for each point and the final result.
`default_nettype none
module icfr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire icfr_pkg::dp_stat_t stat,
	output icfr_pkg::dp_cmd_t       cmd
);
	import icfr_pkg::*;

	state_t state_q, state_d;
	logic   started_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				started_q <= 1'b0;
			end else if (cmd.go) begin
				started_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		cmd.go    = 1'b0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.op   = OP_LOAD;
				cmd.go   = in_valid;
				if (in_valid) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (stat.a_zero) begin
					state_d = stat.last ? ST_FIN : ST_IDLE;
				end else begin
					state_d = ST_X2;
				end
			end
			ST_X2: begin
				cmd.op = OP_X2;
				cmd.go = !started_q;
				if (stat.mul_done) begin
					state_d = ST_X3;
				end
			end
			ST_X3: begin
				cmd.op = OP_X3;
				cmd.go = !started_q;
				if (stat.mul_done) begin
					state_d = ST_T1;
				end
			end
			ST_T1: begin
				cmd.op = OP_T1;
				cmd.go = !started_q;
				if (stat.mul_done) begin
					state_d = ST_T2;
				end
			end
			ST_T2: begin
				cmd.op = OP_T2;
				cmd.go = !started_q;
				if (stat.mul_done) begin
					state_d = ST_T3;
				end
			end
			ST_T3: begin
				cmd.op = OP_T3;
				cmd.go = !started_q;
				if (stat.mul_done) begin
					state_d = ST_T4;
				end
			end
			ST_T4: begin
				cmd.op  = OP_T4;
				cmd.go  = 1'b1;
				state_d = ST_AR;
			end
			ST_AR: begin
				cmd.op = OP_AR;
				cmd.go = !started_q;
				if (stat.mul_done) begin
					state_d = ST_BB;
				end
			end
			ST_BB: begin
				cmd.op = OP_BB;
				cmd.go = !started_q;
				if (stat.mul_done) begin
					state_d = ST_DISC;
				end
			end
			ST_DISC: begin
				cmd.op = OP_DISC;
				cmd.go = 1'b1;
				if (stat.d_neg) begin
					state_d = stat.last ? ST_FIN : ST_IDLE;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.op = OP_SQ;
				cmd.go = !started_q;
				if (stat.sqrt_done) begin
					state_d = ST_DIV1;
				end
			end
			ST_DIV1: begin
				cmd.op = OP_DIV1;
				cmd.go = !started_q;
				if (stat.div_done) begin
					state_d = ST_DIV2;
				end
			end
			ST_DIV2: begin
				cmd.op = OP_DIV2;
				cmd.go = !started_q;
				if (stat.div_done) begin
					state_d = ST_DIST;
				end
			end
			ST_DIST: begin
				cmd.op  = OP_DIST;
				cmd.go  = 1'b1;
				state_d = ST_RES;
			end
			ST_RES: begin
				cmd.op = OP_RES;
				cmd.go = !started_q;
				if (stat.mul_done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				cmd.go  = 1'b1;
				state_d = stat.last ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				cmd.op = OP_FIN;
				cmd.go = !started_q;
				if (stat.sqrt_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> sv/implicit_curve_fit_residual_top.sv
// Top level: register port, controller and datapath of the curve fit residual block.
//
//  channel   direction  handshake               word
//  in        sink       in_valid / in_stall     in_word_t  (x_coord, y_coord, last_point)
//  out       source     out_valid / out_stall   out_word_t (error_root, invalid, saturated)
//  cfg       slave      psel/penable/pready     six 32-bit coefficients at 4*i
//
//  A point with a usable quadratic makes eight passes of the shared
//  32x32 multiplier, a 32-step square root and two 49-step divides.
//  A zero quad_coef ends a point at the check, a negative discriminant at DISC.
//  The last point adds a square root of the sum before out_valid rises.
//  in_stall is high from acceptance until the point ends and any result word is taken;
//  reset clears the sum and flags.
`default_nettype none
module implicit_curve_fit_residual_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire icfr_pkg::in_word_t           in_word,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output icfr_pkg::out_word_t               out_word,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [icfr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [icfr_pkg::COEF_W-1:0]  pwdata,
	output logic [icfr_pkg::COEF_W-1:0]       prdata,
	output logic                              pready
);
	import icfr_pkg::*;

	coef_t            coef_q;
	logic [IDX_W-1:0] idx;
	logic             wr;
	dp_cmd_t          cmd;
	dp_stat_t         stat;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '{quad: QUAD_RESET, lin: '0, cube: '0, square: '0,
				slope: '0, offset: '0};
		end else if (wr) begin
			unique case (idx)
				REG_QUAD:   coef_q.quad   <= $signed(pwdata);
				REG_LIN:    coef_q.lin    <= $signed(pwdata);
				REG_CUBE:   coef_q.cube   <= $signed(pwdata);
				REG_SQUARE: coef_q.square <= $signed(pwdata);
				REG_SLOPE:  coef_q.slope  <= $signed(pwdata);
				REG_OFFSET: coef_q.offset <= $signed(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_QUAD:   prdata = coef_q.quad;
			REG_LIN:    prdata = coef_q.lin;
			REG_CUBE:   prdata = coef_q.cube;
			REG_SQUARE: prdata = coef_q.square;
			REG_SLOPE:  prdata = coef_q.slope;
			REG_OFFSET: prdata = coef_q.offset;
			default:    prdata = '0;
		endcase
	end

	icfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	icfr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.coef     (coef_q),
		.in_word  (in_word),
		.out_word (out_word)
	);

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the implicit curve fit residual block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import icfr_pkg::*;

	localparam longint LMAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint DCLAMP = LMAX >>> 16;
	localparam int CYCLE_LIMIT = 10000000;
	localparam int SETTLE = 400;

	class fit_scoreboard;
		longint coef[NUM_REGS];
		bit [63:0] residual_sum;
		bit invalid_seen, saturation_seen, point_sat;
		out_word_t fit_results[$];
		int mismatches;

		function new();
			coef = '{65536, 0, 0, 0, 0, 0};
			residual_sum = 0;
			invalid_seen = 0;
			saturation_seen = 0;
			mismatches = 0;
		endfunction

		function void set_coef(int idx, logic [31:0] v);
			coef[idx] = longint'($signed(v));
		endfunction

		function bit [63:0] magn(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		function bit [63:0] floor_sqrt(bit [63:0] v);
			bit [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint mul_sat(longint a, longint b);
			bit [63:0] ua, ub;
			bit neg;
			ua = magn(a);
			ub = magn(b);
			neg = (a < 0) != (b < 0);
			if (ua != 0 && ub > 64'(LMAX) / ua) begin
				point_sat = 1;
				return neg ? -LMAX : LMAX;
			end
			return neg ? -longint'(ua * ub) : longint'(ua * ub);
		endfunction

		function longint add_sat(longint a, longint b);
			if (b > 0 && a > LMAX - b) begin
				point_sat = 1;
				return LMAX;
			end
			if (b < 0 && a < -LMAX - b) begin
				point_sat = 1;
				return -LMAX;
			end
			return a + b;
		endfunction

		function void fold_point(longint x, longint y);
			longint a, b, r, d, s, den, r1, r2, yq;
			bit [63:0] d1, d2, near_gap, res;
			a = coef[REG_QUAD];
			b = coef[REG_LIN];
			if (a == 0) begin
				invalid_seen = 1;
				return;
			end
			point_sat = 0;
			r = mul_sat(coef[REG_CUBE], x * x * x);
			r = add_sat(r, mul_sat(coef[REG_SQUARE], x * x));
			r = add_sat(r, mul_sat(coef[REG_SLOPE], x));
			r = add_sat(r, coef[REG_OFFSET]);
			d = add_sat(longint'(64'(b * b) >> 16), mul_sat(mul_sat(a, r) >>> 16, 4));
			if (d < 0) begin
				invalid_seen = 1;
				saturation_seen |= point_sat;
				return;
			end
			if (d > DCLAMP) begin
				d = DCLAMP;
				point_sat = 1;
			end
			s = longint'(floor_sqrt(64'(d) << 16));
			den = 2 * a;
			r1 = ((-b + s) * 65536) / den;
			r2 = ((-b - s) * 65536) / den;
			yq = y * 65536;
			d1 = magn(yq - r1);
			d2 = magn(yq - r2);
			near_gap = d1 < d2 ? d1 : d2;
			if (near_gap >= 64'd1 << 32) begin
				res = '1;
				point_sat = 1;
			end else begin
				res = (near_gap * near_gap) >> 16;
			end
			if (residual_sum > ~res) begin
				residual_sum = '1;
				point_sat = 1;
			end else begin
				residual_sum += res;
			end
			saturation_seen |= point_sat;
		endfunction

		function void note(in_word_t w);
			out_word_t o;
			bit [63:0] root;
			fold_point(longint'(w.x_coord), longint'(w.y_coord));
			if (!w.last_point) return;
			o.saturated = saturation_seen;
			if (residual_sum >= 64'd1 << 48) begin
				root = 64'hffff_ffff;
				o.saturated = 1;
			end else begin
				root = floor_sqrt(residual_sum << 16);
			end
			o.error_root = root[31:0];
			o.invalid = invalid_seen;
			fit_results = {fit_results, o};
			residual_sum = 0;
			invalid_seen = 0;
			saturation_seen = 0;
		endfunction

		function void check(out_word_t got);
			out_word_t exp_w;
			if (fit_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result root=%h inv=%b sat=%b",
						got.error_root, got.invalid, got.saturated);
				return;
			end
			exp_w = fit_results.pop_front();
			if (got !== exp_w) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp root=%h inv=%b sat=%b got root=%h inv=%b sat=%b",
						exp_w.error_root, exp_w.invalid, exp_w.saturated,
						got.error_root, got.invalid, got.saturated);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	in_word_t in_word;
	out_word_t out_word;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [COEF_W-1:0] pwdata, prdata;

	fit_scoreboard sb;
	bit calm;
	int cycles, stall_cnt;

	implicit_curve_fit_residual_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// check, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check(out_word);
		if (stall_cnt > 0) begin
			out_stall <= 1'b1;
			stall_cnt--;
		end else if (!calm && $urandom_range(0, 99) < 12) begin
			out_stall <= 1'b1;
			stall_cnt = $urandom_range(0, 99) < 85 ? $urandom_range(0, 3) :
				$urandom_range(20, 250);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(20, 200);
	endfunction

	task automatic write_coef(logic [IDX_W-1:0] idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_coef(idx, v);
	endtask

	task automatic send_point(int x, int y, bit last);
		in_word_t w;
		int gap;
		w.x_coord = x[11:0];
		w.y_coord = y[11:0];
		w.last_point = last;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		sb.note(w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.fit_results.size() != 0 || in_stall) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_coefs(logic [31:0] q, logic [31:0] l, logic [31:0] c3,
			logic [31:0] c2, logic [31:0] c1, logic [31:0] c0);
		drain();
		write_coef(REG_QUAD, q);
		write_coef(REG_LIN, l);
		write_coef(REG_CUBE, c3);
		write_coef(REG_SQUARE, c2);
		write_coef(REG_SLOPE, c1);
		write_coef(REG_OFFSET, c0);
	endtask

	function automatic logic [31:0] edge_val();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'h1;
			4: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] small_val(int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic random_sets(int n);
		int len, k;
		while (n > 0) begin
			len = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6);
			for (k = 0; k < len; k++)
				send_point($urandom_range(0, 4095), $urandom_range(0, 4095), k == len - 1);
			n -= len;
		end
	endtask

	initial begin
		int ph, q;
		sb = new();
		calm = 0;
		cycles = 0;
		stall_cnt = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		out_stall <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners under reset coefficients
		send_point(0, 0, 1);
		send_point(4095, 4095, 1);
		send_point(4095, 0, 0);
		send_point(0, 4095, 1);
		load_coefs(32'h0, 32'h1_0000, 32'h1, 32'h2, 32'h3, 32'h4);
		send_point(100, 200, 1);
		send_point(5, 6, 0);
		send_point(7, 8, 1);
		load_coefs(32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
		send_point(10, 10, 1);
		send_point(0, 3, 0);
		send_point(1, 3, 1);
		load_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff);
		send_point(4095, 4095, 1);
		send_point(0, 0, 1);
		load_coefs(32'h1, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
		repeat (6) send_point($urandom_range(0, 4095), 4095, 0);
		send_point(4095, 0, 1);
		load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		send_point(4095, 4095, 1);
		send_point(1, 1, 1);

		for (ph = 0; ph < 17; ph++) begin
			calm = (ph % 5 == 2);
			q = ph % 4;
			if (q == 0)
				load_coefs(32'($signed($urandom_range(1, 4)) * 65536 *
					($urandom_range(0, 1) ? 1 : -1)), small_val(200000),
					small_val(2), small_val(300), small_val(2000000), small_val(2000000000));
			else if (q == 1)
				load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else if (q == 2)
				load_coefs(edge_val(), edge_val(), edge_val(), edge_val(), edge_val(),
					edge_val());
			else
				load_coefs(32'h1_0000, small_val(65536), 32'h0, small_val(20),
					small_val(100000), small_val(50000000));
			random_sets(100);
			if (ph == 8) begin
				in_valid <= 1'b0;
				while (sb.fit_results.size() != 0) @(posedge clk);
			end
		end

		calm = 0;
		in_valid <= 1'b0;
		while (sb.fit_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.mismatches == 0 && sb.fit_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
